@@ rtl/adrp_pkg.sv @@
// Shared types, constants and codes for the ADRP reference scanner.
// Used by the channel interfaces and every scanner module.
package adrp_pkg;

   localparam int ADDR_W = 64;
   localparam int WORD_W = 32;
   localparam int ORD_W  = 16;
   localparam int OFS_W  = 24;

   // Queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Configuration register indexes
   localparam logic [1:0] CSR_REGION_BASE   = 2'd0;
   localparam logic [1:0] CSR_TARGET_ADDR   = 2'd1;
   localparam logic [1:0] CSR_ORDINAL       = 2'd2;
   localparam logic [1:0] CSR_INDIRECT_MODE = 2'd3;

   // Result status codes
   localparam logic [1:0] STATUS_FOUND     = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_AMBIG     = 2'd2;

   // Decision held by the back end within one stream
   localparam logic [1:0] OUT_UNDECIDED = 2'd0;
   localparam logic [1:0] OUT_FOUND     = 2'd1;
   localparam logic [1:0] OUT_AMBIG     = 2'd2;

   // Instruction encodings
   localparam logic [31:0] ADRP_MASK   = 32'h9F00_0000;
   localparam logic [31:0] ADRP_MATCH  = 32'h9000_0000;
   localparam logic [31:0] ADD_MASK    = 32'h7F80_0000;
   localparam logic [31:0] ADD_MATCH   = 32'h1100_0000;
   localparam logic [31:0] LDR_MASK    = 32'hFFC0_0000;
   localparam logic [31:0] LDR_MATCH   = 32'hF940_0000;

   typedef struct packed {
      logic [ADDR_W-1:0] region_base;
      logic [ADDR_W-1:0] target_address;
      logic [ORD_W-1:0]  ordinal;
      logic              indirect_mode;
   } adrp_cfg_type;

   // One classified word pair
   typedef struct packed {
      logic [ADDR_W-1:0] page;
      logic [OFS_W-1:0]  offset;
      logic [ADDR_W-1:0] hit_pc;
      logic              match;
      logic              last;
   } adrp_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } adrp_q_status_type;

endpackage

@@ rtl/adrp_ifs.sv @@
// Valid/ready channel interfaces for the scanner's word input and result output.
// Depends on adrp_pkg for field widths.
interface adrp_req_if import adrp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] instruction_word;
   logic              last_word;

   modport source (output valid, instruction_word, last_word, input ready);
   modport sink   (input valid, instruction_word, last_word, output ready);
endinterface

interface adrp_rsp_if import adrp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] reference_address;
   logic [1:0]        scan_status;

   modport source (output valid, reference_address, scan_status, input ready);
   modport sink   (input valid, reference_address, scan_status, output ready);
endinterface

@@ rtl/adrp_front.sv @@
// Front end: accepts instruction words, tracks the previous word and its PC,
// decodes each adjacent pair and forms the ADRP page. Depends on adrp_pkg.
module adrp_front import adrp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  adrp_cfg_type      cfg,
   adrp_req_if.sink          req,
   input  adrp_q_status_type q_stat,
   output logic              push,
   output adrp_entry_type    push_entry
);

   logic [WORD_W-1:0] prev_word_ff, prev_word_in;
   logic [ADDR_W-1:0] prev_pc_ff, prev_pc_in;
   logic              prev_valid_ff, prev_valid_in;

   logic [WORD_W-1:0] cur_word;
   logic              is_adrp;
   logic [20:0]       adrp_imm;
   logic [51:0]       page_hi;
   logic              rn_match;
   logic [11:0]       imm12;
   logic              op_ok;
   logic [OFS_W-1:0]  offset;

   assign req.ready = !q_stat.full;
   assign push      = req.valid && !q_stat.full;
   assign cur_word  = req.instruction_word;

   // Decode the ADRP in the previous word and form its page
   always_comb begin
      is_adrp  = (prev_word_ff & ADRP_MASK) == ADRP_MATCH;
      adrp_imm = {prev_word_ff[23:5], prev_word_ff[30:29]};
      page_hi  = prev_pc_ff[ADDR_W-1:12] + {{31{adrp_imm[20]}}, adrp_imm};
   end

   // Decode the second word of the pair
   always_comb begin
      rn_match = cur_word[9:5] == prev_word_ff[4:0];
      imm12    = cur_word[21:10];
      if (cfg.indirect_mode) begin
         op_ok  = (cur_word & LDR_MASK) == LDR_MATCH;
         offset = {9'd0, imm12, 3'd0};
      end else begin
         op_ok  = (cur_word & ADD_MASK) == ADD_MATCH;
         offset = cur_word[22] ? {imm12, 12'd0} : {12'd0, imm12};
      end
   end

   always_comb begin
      push_entry.page   = {page_hi, 12'd0};
      push_entry.offset = offset;
      push_entry.hit_pc = prev_pc_ff;
      push_entry.match  = prev_valid_ff && is_adrp && rn_match && op_ok;
      push_entry.last   = req.last_word;
   end

   // Advance the previous-word state, drop it at the end of a stream
   always_comb begin
      prev_word_in  = prev_word_ff;
      prev_pc_in    = prev_pc_ff;
      prev_valid_in = prev_valid_ff;
      if (push) begin
         prev_word_in  = cur_word;
         prev_pc_in    = prev_valid_ff ? prev_pc_ff + ADDR_W'(4) : cfg.region_base;
         prev_valid_in = !req.last_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_valid_ff <= 1'b0;
      end else begin
         prev_valid_ff <= prev_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_word_ff <= prev_word_in;
      prev_pc_ff   <= prev_pc_in;
   end

endmodule

@@ rtl/adrp_queue.sv @@
// Short queue of classified pairs between the front and back ends.
// Depends on adrp_pkg for the entry type and depth.
module adrp_queue import adrp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  adrp_entry_type    push_entry,
   input  logic              pop,
   output adrp_entry_type    head,
   output adrp_q_status_type q_stat
);

   adrp_entry_type     mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;

   assign head         = mem_ff[rd_ptr_ff];
   assign q_stat.full  = count_ff == Q_CNT_W'(Q_DEPTH);
   assign q_stat.empty = count_ff == '0;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !push)
      else $error("queue pushed while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_stat.empty |-> !pop)
      else $error("queue popped while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("queue occupancy beyond depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      count_ff != Q_CNT_W'(Q_DEPTH) |->
         Q_CNT_W'(Q_PTR_W'(wr_ptr_ff - rd_ptr_ff)) == count_ff)
      else $error("queue pointers disagree with occupancy");

endmodule

@@ rtl/adrp_back.sv @@
// Back end: completes the pair address, counts hits, decides the outcome and
// holds the result in an output register. Depends on adrp_pkg.
module adrp_back import adrp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  adrp_cfg_type      cfg,
   input  adrp_entry_type    head,
   input  adrp_q_status_type q_stat,
   output logic              pop,
   adrp_rsp_if.source        rsp
);

   logic [ORD_W-1:0]  hit_count_ff, hit_count_in;
   logic [ADDR_W-1:0] first_hit_ff, first_hit_in;
   logic [1:0]        decided_ff, decided_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   logic [ADDR_W-1:0] pair_addr;
   logic              hit;
   logic [ORD_W-1:0]  cnt_upd;
   logic [1:0]        dec_upd;
   logic [ADDR_W-1:0] first_upd;
   logic              slot_free;

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign pop       = !q_stat.empty && (!head.last || slot_free);

   // Complete the address and compare against the target
   always_comb begin
      pair_addr = head.page + {{(ADDR_W-OFS_W){1'b0}}, head.offset};
      hit       = head.match && (head.page != '0) && (pair_addr != '0) &&
                  (pair_addr == cfg.target_address) && (decided_ff == OUT_UNDECIDED);
   end

   // Count the hit and decide
   always_comb begin
      cnt_upd   = hit_count_ff;
      dec_upd   = decided_ff;
      first_upd = first_hit_ff;
      if (hit) begin
         if (hit_count_ff != '1) begin
            cnt_upd = hit_count_ff + 1'b1;
         end
         if (cfg.ordinal != '0) begin
            if (cnt_upd == cfg.ordinal) begin
               dec_upd   = OUT_FOUND;
               first_upd = head.hit_pc;
            end
         end else if (cnt_upd >= ORD_W'(2)) begin
            dec_upd = OUT_AMBIG;
         end else begin
            first_upd = head.hit_pc;
         end
      end
   end

   // Hold state per stream, clear it on the last transaction
   always_comb begin
      hit_count_in  = hit_count_ff;
      first_hit_in  = first_hit_ff;
      decided_in    = decided_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      if (pop) begin
         hit_count_in = cnt_upd;
         first_hit_in = first_upd;
         decided_in   = dec_upd;
         if (head.last) begin
            hit_count_in = '0;
            first_hit_in = '0;
            decided_in   = OUT_UNDECIDED;
            rsp_valid_in = 1'b1;
            if (dec_upd == OUT_FOUND) begin
               rsp_addr_in   = first_upd;
               rsp_status_in = STATUS_FOUND;
            end else if (dec_upd == OUT_AMBIG) begin
               rsp_addr_in   = '0;
               rsp_status_in = STATUS_AMBIG;
            end else if (cfg.ordinal == '0 && cnt_upd != '0) begin
               rsp_addr_in   = first_upd;
               rsp_status_in = STATUS_FOUND;
            end else begin
               rsp_addr_in   = '0;
               rsp_status_in = STATUS_NOT_FOUND;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_count_ff <= '0;
         first_hit_ff <= '0;
         decided_ff   <= OUT_UNDECIDED;
         rsp_valid_ff <= 1'b0;
      end else begin
         hit_count_ff <= hit_count_in;
         first_hit_ff <= first_hit_in;
         decided_ff   <= decided_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.reference_address = rsp_addr_ff;
   assign rsp.scan_status       = rsp_status_ff;

   a_addr_zero_unless_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_FOUND |-> rsp_addr_ff == '0)
      else $error("address given without a found status");

   a_ambig_needs_zero_ordinal: assert property (@(posedge clock) disable iff (reset)
      decided_ff == OUT_AMBIG |-> cfg.ordinal == '0)
      else $error("ambiguous decision with an ordinal set");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      pop && head.last |-> slot_free)
      else $error("result register overwritten while held");

   a_decided_holds_count: assert property (@(posedge clock) disable iff (reset)
      decided_ff != OUT_UNDECIDED && !(pop && head.last) |=>
         $stable(hit_count_ff))
      else $error("hit count moved after a decision");

endmodule

@@ rtl/adrp_reference_scanner.sv @@
// ADRP reference scanner, top level.
// Holds the configuration registers and joins front, queue and back end.
//
// Use: program region_base, target_address, ordinal and indirect_mode through
// the csr_ write port while the scanner is idle, then stream the instruction
// words of the region on req, in address order, marking the final word with
// last_word. Each ADRP followed by a matching ADD (or LDR in indirect mode)
// whose address equals the target counts as a hit. One result transaction
// leaves on rsp for every last word: the chosen ADRP's address and a status
// of found, not found or ambiguous.
// Throughput: one word per cycle while the queue has room. The front end
// decodes the pair and forms the page; a four-entry queue hands pairs to the
// back end, which completes the address, compares and counts, and loads the
// output register. The last word is written into the queue and, once every
// entry ahead of it is popped, loaded into the output register (rsp.valid).
// A stalled rsp holds the result; words keep flowing until a second last word
// reaches the back end and the queue fills, then req.ready drops.
// Reset: synchronous, clears all configuration to zero and empties the
// queue, the stream state and the output register.
module adrp_reference_scanner import adrp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   adrp_req_if.sink          req,
   adrp_rsp_if.source        rsp,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [ADDR_W-1:0] csr_write_data
);

   adrp_cfg_type      cfg_ff, cfg_in;
   adrp_q_status_type q_stat;
   adrp_entry_type    push_entry;
   adrp_entry_type    head;
   logic              push;
   logic              pop;

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_REGION_BASE:   cfg_in.region_base    = csr_write_data;
            CSR_TARGET_ADDR:   cfg_in.target_address = csr_write_data;
            CSR_ORDINAL:       cfg_in.ordinal        = csr_write_data[ORD_W-1:0];
            CSR_INDIRECT_MODE: cfg_in.indirect_mode  = csr_write_data[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   adrp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   adrp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   adrp_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .head   (head),
      .q_stat (q_stat),
      .pop    (pop),
      .rsp    (rsp)
   );

endmodule

@@ sim/adrp_reference_scanner_tb.sv @@
// Self-checking testbench for adrp_reference_scanner: directed table, then random streams.
// Depends on adrp_pkg and the adrp_req_if / adrp_rsp_if channel interfaces.
module adrp_reference_scanner_tb;
   import adrp_pkg::*;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [1:0]        status;
   } xref_type;

   typedef struct {
      logic              is_cfg;
      logic [1:0]        idx;
      logic [ADDR_W-1:0] data;
      logic [WORD_W-1:0] word;
      logic              last;
      logic              pinned;
      xref_type          want;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic [1:0]        csr_index;
   logic [ADDR_W-1:0] csr_write_data;

   adrp_req_if req_ch ();
   adrp_rsp_if rsp_ch ();

   adrp_reference_scanner u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow configuration and stream state of the scanner
   logic [ADDR_W-1:0] cfg_base;
   logic [ADDR_W-1:0] cfg_target;
   logic [ORD_W-1:0]  cfg_ordinal;
   logic              cfg_indirect;
   logic [WORD_W-1:0] held_word;
   logic              held_valid;
   logic [ADDR_W-1:0] held_pc;
   logic [ORD_W-1:0]  hits;
   logic [ADDR_W-1:0] hit_pc;
   logic [1:0]        outcome;

   xref_type     expected_xrefs[$];
   stim_row_type directed_rows[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int n_errors       = 0;
   int n_words        = 0;
   int n_streams      = 0;
   int n_settings     = 0;
   int n_found        = 0;
   int n_missing      = 0;
   int n_ambig        = 0;

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [31:0] enc_adrp(input logic [4:0] rd, input logic [20:0] imm21);
      return {1'b1, imm21[1:0], 5'b10000, imm21[20:2], rd};
   endfunction

   function automatic logic [31:0] enc_add(input logic sf, input logic sh,
                                           input logic [11:0] imm12,
                                           input logic [4:0] rn, input logic [4:0] rd);
      return {sf, 8'b0010_0010, sh, imm12, rn, rd};
   endfunction

   function automatic logic [31:0] enc_ldr(input logic [11:0] imm12,
                                           input logic [4:0] rn, input logic [4:0] rt);
      return {10'b11_1110_0101, imm12, rn, rt};
   endfunction

   // Address formed by an ADRP at pc followed by word b, zero when they do not pair or the page is zero
   function automatic logic [63:0] pair_xref_addr(input logic [63:0] pc,
                                                  input logic [31:0] a, input logic [31:0] b);
      logic [20:0] imm21;
      logic [63:0] page;
      logic [11:0] imm12;
      if ((a & ADRP_MASK) != ADRP_MATCH) return '0;
      imm21 = {a[23:5], a[30:29]};
      page  = {pc[63:12], 12'h000} + ({{43{imm21[20]}}, imm21} << 12);
      if (page == '0) return '0;
      if (b[9:5] != a[4:0]) return '0;
      imm12 = b[21:10];
      if (cfg_indirect) begin
         if ((b & LDR_MASK) != LDR_MATCH) return '0;
         return page + {49'b0, imm12, 3'b000};
      end
      if ((b & ADD_MASK) != ADD_MATCH) return '0;
      return b[22] ? page + {40'b0, imm12, 12'h000} : page + {52'b0, imm12};
   endfunction

   function automatic void clear_stream();
      held_word  = '0;
      held_valid = 1'b0;
      held_pc    = '0;
      hits       = '0;
      hit_pc     = '0;
      outcome    = OUT_UNDECIDED;
   endfunction

   // Advance the shadow state by one word; a last word yields the scan result
   function automatic void xref_step(input logic [31:0] w, input logic last,
                                     output logic produced, output xref_type res);
      logic [63:0] pc;
      logic [63:0] addr;
      produced = 1'b0;
      res      = '0;
      pc = held_valid ? held_pc + 64'd4 : cfg_base;
      if (held_valid && outcome == OUT_UNDECIDED) begin
         addr = pair_xref_addr(held_pc, held_word, w);
         if (addr != '0 && addr == cfg_target) begin
            if (hits != 16'hFFFF) hits++;
            if (cfg_ordinal != '0) begin
               if (hits == cfg_ordinal) begin
                  outcome = OUT_FOUND;
                  hit_pc  = held_pc;
               end
            end else if (hits >= 2) begin
               outcome = OUT_AMBIG;
            end else begin
               hit_pc = held_pc;
            end
         end
      end
      held_word  = w;
      held_pc    = pc;
      held_valid = 1'b1;
      if (last) begin
         produced = 1'b1;
         if (outcome == OUT_FOUND || (outcome == OUT_UNDECIDED && cfg_ordinal == '0
                                      && hits >= 1))
            res = '{addr: hit_pc, status: STATUS_FOUND};
         else if (outcome == OUT_AMBIG)
            res = '{addr: '0, status: STATUS_AMBIG};
         else
            res = '{addr: '0, status: STATUS_NOT_FOUND};
         clear_stream();
      end
   endfunction

   // Directed table builders
   function automatic void tab_cfg(input logic [1:0] idx, input logic [63:0] value);
      stim_row_type r;
      r = '{1'b1, idx, value, 32'h0, 1'b0, 1'b0, '0};
      directed_rows.push_back(r);
   endfunction

   function automatic void tab_word(input logic [31:0] w, input logic last);
      stim_row_type r;
      r = '{1'b0, CSR_REGION_BASE, 64'h0, w, last, 1'b0, '0};
      directed_rows.push_back(r);
   endfunction

   function automatic void tab_end(input logic [31:0] w, input logic [63:0] addr,
                                   input logic [1:0] status);
      stim_row_type r;
      xref_type     want;
      want = '{addr: addr, status: status};
      r = '{1'b0, CSR_REGION_BASE, 64'h0, w, 1'b1, 1'b1, want};
      directed_rows.push_back(r);
   endfunction

   // Drop valid and wait until every result is back and the pipe is quiet
   task automatic drain_scanner();
      req_ch.valid <= 1'b0;
      while (expected_xrefs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
      drain_scanner();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_REGION_BASE:   cfg_base     = value;
         CSR_TARGET_ADDR:   cfg_target   = value;
         CSR_ORDINAL:       cfg_ordinal  = value[ORD_W-1:0];
         CSR_INDIRECT_MODE: cfg_indirect = value[0];
         default: ;
      endcase
   endtask

   // Present one word, hold it until accepted, then record what it should yield
   task automatic send_word(input logic [31:0] w, input logic last,
                            input logic pinned, input xref_type pinned_res);
      logic     produced;
      xref_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.instruction_word <= w;
      req_ch.last_word        <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      xref_step(w, last, produced, predicted);
      n_words++;
      if (produced) begin
         n_streams++;
         expected_xrefs.push_back(pinned ? pinned_res : predicted);
      end
   endtask

   // Build an ADRP pair at pc that lands on the current target where it can
   function automatic void make_pair(input logic [63:0] pc,
                                     output logic [31:0] a, output logic [31:0] b);
      logic [11:0] imm12;
      logic        sh;
      logic [63:0] off;
      logic [63:0] page;
      logic [63:0] delta;
      logic [4:0]  rd;
      rd = 5'($urandom);
      sh = 1'b0;
      if (cfg_indirect) begin
         imm12 = {3'($urandom), cfg_target[11:3]};
         off   = {49'b0, imm12, 3'b000};
      end else if (cfg_target[11:0] == 12'h000 && $urandom_range(1) == 1) begin
         sh    = 1'b1;
         imm12 = 12'($urandom);
         off   = {40'b0, imm12, 12'h000};
      end else begin
         imm12 = cfg_target[11:0];
         off   = {52'b0, imm12};
      end
      page  = cfg_target - off;
      delta = page - {pc[63:12], 12'h000};
      a = enc_adrp(rd, delta[32:12]);
      b = cfg_indirect ? enc_ldr(imm12, rd, 5'($urandom))
                       : enc_add(1'($urandom), sh, imm12, rd, 5'($urandom));
   endfunction

   // Break a good pair in one place
   function automatic void spoil_pair(inout logic [31:0] a, inout logic [31:0] b);
      int bit_i;
      case ($urandom_range(4))
         0: b[9:5] = b[9:5] ^ 5'($urandom_range(1, 31));
         1: begin
            bit_i    = 10 + $urandom_range(11);
            b[bit_i] = ~b[bit_i];
         end
         2: a[31] = 1'b0;
         3: b = cfg_indirect ? enc_add(1'b1, 1'b0, b[21:10], b[9:5], b[4:0])
                             : enc_ldr(b[21:10], b[9:5], b[4:0]);
         default: begin
            bit_i    = 5 + $urandom_range(18);
            a[bit_i] = ~a[bit_i];
         end
      endcase
   endfunction

   function automatic logic [31:0] noise_word();
      case ($urandom_range(5))
         0: return enc_adrp(5'($urandom), 21'($urandom));
         1: return enc_add(1'($urandom), 1'($urandom), 12'($urandom),
                           5'($urandom), 5'($urandom));
         2: return enc_ldr(12'($urandom), 5'($urandom), 5'($urandom));
         default: return $urandom;
      endcase
   endfunction

   // One region: good pairs, spoilt pairs and noise, closed by a last word
   task automatic run_stream(inout int n_random);
      logic [31:0] words[$];
      logic [31:0] a;
      logic [31:0] b;
      int          len;
      int          k;
      int          pick;
      len = ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 10);
      k   = 0;
      while (k < len) begin
         pick = $urandom_range(99);
         if (pick < 45 && k + 1 < len) begin
            make_pair(cfg_base + 64'(4 * k), a, b);
            if (pick >= 32) spoil_pair(a, b);
            words.push_back(a);
            words.push_back(b);
            k += 2;
         end else begin
            words.push_back(noise_word());
            k++;
         end
      end
      foreach (words[i]) send_word(words[i], i == words.size() - 1, 1'b0, '0);
      n_random += len;
   endtask

   task automatic random_settings();
      logic [63:0] base;
      logic [63:0] tgt;
      logic [31:0] span;
      logic [15:0] ord;
      logic        ind;
      case ($urandom_range(9))
         0:       base = '0;
         1:       base = '1 - 64'($urandom_range(255));
         default: base = {$urandom, $urandom};
      endcase
      ind  = 1'($urandom);
      span = $urandom;
      tgt  = base + {{32{span[31]}}, span};
      if (ind && $urandom_range(4) != 0) tgt[2:0] = 3'b000;
      if (!ind && $urandom_range(2) == 0) tgt[11:0] = 12'h000;
      if ($urandom_range(9) == 0) tgt = {$urandom, $urandom};
      case ($urandom_range(9))
         0, 1, 2, 3: ord = '0;
         9:          ord = 16'($urandom);
         default:    ord = 16'($urandom_range(1, 3));
      endcase
      write_reg(CSR_REGION_BASE, base);
      write_reg(CSR_TARGET_ADDR, tgt);
      write_reg(CSR_ORDINAL, {48'b0, ord});
      write_reg(CSR_INDIRECT_MODE, {63'b0, ind});
      n_settings++;
   endtask

   // Result side: check each transaction against the oldest expectation, stall at random
   initial begin
      xref_type want;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            case (rsp_ch.scan_status)
               STATUS_FOUND:     n_found++;
               STATUS_NOT_FOUND: n_missing++;
               default:          n_ambig++;
            endcase
            if (expected_xrefs.size() == 0) begin
               if (n_errors < 10)
                  $display("[%0t] unexpected result: addr=%h status=%0d", $time,
                           rsp_ch.reference_address, rsp_ch.scan_status);
               n_errors++;
            end else begin
               want = expected_xrefs.pop_front();
               if (rsp_ch.reference_address !== want.addr
                   || rsp_ch.scan_status !== want.status) begin
                  if (n_errors < 10)
                     $display("[%0t] mismatch: exp %h/%0d, got %h/%0d",
                              $time, want.addr, want.status,
                              rsp_ch.reference_address, rsp_ch.scan_status);
                  n_errors++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Stimulus and verdict
   initial begin
      int n_random;
      int block_end;
      reset                   = 1'b1;
      req_ch.valid            = 1'b0;
      req_ch.instruction_word = '0;
      req_ch.last_word        = 1'b0;
      csr_write_enable        = 1'b0;
      csr_index               = CSR_REGION_BASE;
      csr_write_data          = '0;
      cfg_base                = '0;
      cfg_target              = '0;
      cfg_ordinal             = '0;
      cfg_indirect            = 1'b0;
      clear_stream();
      n_random = 0;

      // Lone word straight after reset: no pair can form
      tab_end(32'hFFFF_FFFF, 64'h0, STATUS_NOT_FOUND);
      // Direct mode, unique hit
      tab_cfg(CSR_REGION_BASE, 64'h4000_0000);
      tab_cfg(CSR_TARGET_ADDR, 64'h4000_0234);
      tab_cfg(CSR_ORDINAL, 64'h0);
      tab_cfg(CSR_INDIRECT_MODE, 64'h0);
      tab_word(enc_adrp(5'd3, 21'h0), 1'b0);
      tab_end(enc_add(1'b1, 1'b0, 12'h234, 5'd3, 5'd3), 64'h4000_0000, STATUS_FOUND);
      // Two hits with ordinal zero is ambiguous
      tab_word(enc_adrp(5'd3, 21'h0), 1'b0);
      tab_word(enc_add(1'b1, 1'b0, 12'h234, 5'd3, 5'd3), 1'b0);
      tab_word(32'h0000_0000, 1'b0);
      tab_word(enc_adrp(5'd7, 21'h0), 1'b0);
      tab_word(enc_add(1'b1, 1'b0, 12'h234, 5'd7, 5'd1), 1'b0);
      tab_end(32'hD503_201F, 64'h0, STATUS_AMBIG);
      // Same words in a new stream, second hit chosen by ordinal
      tab_cfg(CSR_ORDINAL, 64'h2);
      tab_word(enc_adrp(5'd3, 21'h0), 1'b0);
      tab_word(enc_add(1'b1, 1'b0, 12'h234, 5'd3, 5'd3), 1'b0);
      tab_word(32'h0000_0000, 1'b0);
      tab_word(enc_adrp(5'd7, 21'h0), 1'b0);
      tab_word(enc_add(1'b1, 1'b0, 12'h234, 5'd7, 5'd1), 1'b0);
      tab_end(32'hD503_201F, 64'h4000_000C, STATUS_FOUND);
      // Indirect mode, scaled offset
      tab_cfg(CSR_INDIRECT_MODE, 64'h1);
      tab_cfg(CSR_TARGET_ADDR, 64'h4000_0FF8);
      tab_cfg(CSR_ORDINAL, 64'h1);
      tab_word(enc_adrp(5'd5, 21'h0), 1'b0);
      tab_end(enc_ldr(12'h1FF, 5'd5, 5'd0), 64'h4000_0000, STATUS_FOUND);
      // Page zero never counts, even when the address matches
      tab_cfg(CSR_REGION_BASE, 64'h0);
      tab_cfg(CSR_TARGET_ADDR, 64'h8);
      tab_word(enc_adrp(5'd1, 21'h0), 1'b0);
      tab_end(enc_ldr(12'h001, 5'd1, 5'd2), 64'h0, STATUS_NOT_FOUND);
      // Top of the address space, pc wraps to zero
      tab_cfg(CSR_REGION_BASE, 64'hFFFF_FFFF_FFFF_FFFC);
      tab_cfg(CSR_TARGET_ADDR, 64'hFFFF_FFFF_FFFF_FFFF);
      tab_cfg(CSR_INDIRECT_MODE, 64'h0);
      tab_word(enc_adrp(5'd2, 21'h0), 1'b0);
      tab_end(enc_add(1'b0, 1'b0, 12'hFFF, 5'd2, 5'd2), 64'hFFFF_FFFF_FFFF_FFFC, STATUS_FOUND);
      // Ordinal out of reach
      tab_cfg(CSR_ORDINAL, 64'hFFFF);
      tab_word(enc_adrp(5'd2, 21'h0), 1'b0);
      tab_end(enc_add(1'b0, 1'b0, 12'hFFF, 5'd2, 5'd2), 64'h0, STATUS_NOT_FOUND);
      // Most negative page offset
      tab_word(enc_adrp(5'd0, 21'h10_0000), 1'b0);
      tab_word(32'hFFFF_FFFF, 1'b1);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_cfg)
            write_reg(directed_rows[i].idx, directed_rows[i].data);
         else
            send_word(directed_rows[i].word, directed_rows[i].last,
                      directed_rows[i].pinned, directed_rows[i].want);
      end

      // Random streams across the idling phases, new settings every block
      while (n_random < 700) begin
         case (n_random * 4 / 700)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         random_settings();
         block_end = n_random + $urandom_range(40, 70);
         while (n_random < block_end) run_stream(n_random);
      end

      drain_scanner();
      repeat (8) @(posedge clock);

      $display("Covered %0d words in %0d regions over %0d random settings",
               n_words, n_streams, n_settings);
      $display("Results seen: %0d found, %0d not found, %0d ambiguous, %0d errors",
               n_found, n_missing, n_ambig, n_errors);
      if (n_errors == 0 && expected_xrefs.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
